/* design/rps_pkg.sv */
// ----------------------------------------------------------------------------
// rps_pkg: shared constants for the random permutation shuffle
// Field widths and reset values used by the top level and the divider.
// ----------------------------------------------------------------------------
package rps_pkg;

    // Random word width, also the step count of the serial divider; config and output field widths
    localparam int WORD_W       = 31;
    localparam int CFG_W        = 9;
    localparam int OUT_W        = 8;

    // Defaults
    localparam int DEF_MAX_LEN  = 256;
    localparam logic [CFG_W-1:0] PERM_LEN_RST = 9'd8;

endpackage

/* design/random_permutation_shuffle_top.sv */
// ----------------------------------------------------------------------------
// random_permutation_shuffle_top: Fisher-Yates permutation generator
//
// Input stream (s_*): tdata carries a 31-bit random word, tuser the restart
// flag. Each request yields one result on the output stream (m_*): tdata
// holds the slot and the chosen index, tlast marks slot zero.
// Slots count down from length-1. A new permutation begins when restart is
// set or when the previous one has finished; its length is taken from the
// configuration channel (cfg_*), clamped to 1..MAX_LEN, at that moment.
// Each request passes the bit-serial remainder unit, a hand-over of the remainder
// to the sequencer, three steps in the single-port index store (read r, read
// slot, write back r) and a load of the output register.
// The block takes one request at a time: the input is ready again once the
// result of the last request is loaded into the output register.
// The next request is taken while a result still waits in the output
// register; a held result stalls the following one in its final step.
// Reset: length 8, no permutation running, written map clear, output empty.
// The index store needs no clearing: an entry not written in the current
// permutation reads as its own position.
// ----------------------------------------------------------------------------
module random_permutation_shuffle_top
    import rps_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration write channel: perm_length
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    // Request stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // [30:0] random_word, [31] zero pad
    input  logic [0:0]       s_tuser,   // [0] restart
    // Result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [7:0] slot, [15:8] chosen_index
    output logic             m_tlast    // last
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int IW = $clog2(MAX_LEN);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD_R,
        ST_RD_I,
        ST_WR,
        ST_PUSH
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_perm_len;
    logic [LW-1:0]      r_remaining;
    logic [MAX_LEN-1:0] r_map;
    logic [IW-1:0]      r_slot;
    logic [IW-1:0]      r_r;
    logic [IW-1:0]      r_val_r;
    logic [IW-1:0]      r_rd_data;
    logic [IW-1:0]      r_mem [MAX_LEN];
    logic               r_m_valid;
    logic [OUT_W-1:0]   r_m_slot;
    logic [OUT_W-1:0]   r_m_idx;
    logic               r_m_last;

    logic               w_in_acc;
    logic               w_start;
    logic [LW-1:0]      w_eff;
    logic [LW-1:0]      w_rem_n;
    logic               w_div_done;
    logic [IW-1:0]      w_div_rem;
    logic [IW-1:0]      w_val_i;
    logic [IW-1:0]      w_rd_addr;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_len <= PERM_LEN_RST;
        end else if (i_cfg_valid) begin
            r_perm_len <= i_cfg_data;
        end
    end

    // Clamp the length and pick the count for this request
    always_comb begin
        if (r_perm_len == '0) begin
            w_eff = LW'(1);
        end else if (32'(r_perm_len) > MAX_LEN) begin
            w_eff = LW'(MAX_LEN);
        end else begin
            w_eff = LW'(r_perm_len);
        end
        w_start = s_tuser[0] || (r_remaining == '0);
        w_rem_n = w_start ? w_eff : r_remaining;
    end

    assign s_tready = (r_state == ST_IDLE);
    assign w_in_acc = s_tvalid && s_tready;

    // Remainder of the random word by the current count
    rps_divmod #(
        .MAX_LEN    (MAX_LEN)
    ) u_divmod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_dividend (s_tdata[WORD_W-1:0]),
        .i_divisor  (w_rem_n),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    // Index store: one port, registered read, entry at r first then slot
    assign w_rd_addr = (r_state == ST_RD_R) ? r_r : r_slot;
    assign w_val_i   = r_map[r_slot] ? r_rd_data : r_slot;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WR) begin
            r_mem[r_r] <= w_val_i;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_remaining <= '0;
            r_map       <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            // Drop the result once taken, unless a new one is loaded now
            if (r_m_valid && m_tready && (r_state != ST_PUSH)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (w_start) begin
                            r_map <= '0;
                        end
                        r_remaining <= w_rem_n - 1'b1;
                        r_slot      <= IW'(w_rem_n - 1'b1);
                        r_state     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_r     <= w_div_rem;
                        r_state <= ST_RD_R;
                    end
                end
                ST_RD_R: begin
                    r_state <= ST_RD_I;
                end
                ST_RD_I: begin
                    r_val_r <= r_map[r_r] ? r_rd_data : r_r;
                    r_state <= ST_WR;
                end
                ST_WR: begin
                    r_map[r_r] <= 1'b1;
                    r_state    <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!r_m_valid || m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_slot  <= OUT_W'(r_slot);
                        r_m_idx   <= OUT_W'(r_val_r);
                        r_m_last  <= (r_slot == '0);
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {r_m_idx, r_m_slot};
    assign m_tlast  = r_m_last;

    // Checks
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !s_tready)
        else $error("request taken while a draw is in progress");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("remainder finished outside the divide step");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD_R) |-> (r_r <= r_slot))
        else $error("drawn position above the current slot");

    a_map_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) |=> r_map[$past(r_r)])
        else $error("written map not set after write-back");

    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH && r_slot == '0) |-> (r_remaining == '0))
        else $error("last slot with permutation still running");

endmodule

/* design/rps_divmod.sv */
// ----------------------------------------------------------------------------
// rps_divmod: bit-serial restoring remainder unit
// Takes one dividend bit per cycle; once the last bit is in, it pulses
// done with the remainder of the dividend by the divisor.
// ----------------------------------------------------------------------------
module rps_divmod
    import rps_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [WORD_W-1:0]            i_dividend,
    input  logic [$clog2(MAX_LEN+1)-1:0] i_divisor,
    output logic                         o_done,
    output logic [$clog2(MAX_LEN)-1:0]   o_rem
);

    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int IW    = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(WORD_W);

    logic [WORD_W-1:0] r_dvd;
    logic [LW-1:0]     r_dsr;
    logic [LW-1:0]     r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [LW:0]       w_trial;
    logic [LW:0]       w_next;

    // Shift in the next dividend bit, subtract when the divisor fits
    always_comb begin
        w_trial = {r_rem, r_dvd[WORD_W-1]};
        if (w_trial >= {1'b0, r_dsr}) begin
            w_next = w_trial - {1'b0, r_dsr};
        end else begin
            w_next = w_trial;
        end
    end

    // Step the partial remainder once per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd  <= i_dividend;
                r_dsr  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
                r_rem <= w_next[LW-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    // Remainder is below the divisor, which is at most MAX_LEN
    assign o_rem  = r_rem[IW-1:0];

endmodule

/* bench/random_permutation_shuffle_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_permutation_shuffle_top_tb: self-checking bench for the shuffle block
// Drives random words and restart flags into the request stream and runs a
// local Fisher-Yates model in step with every accepted request. Each result
// on the output stream is checked against the oldest predicted draw. The
// length register is swept through its extremes: zero, one, the maximum,
// and values above the maximum. It is also changed in the middle of a
// permutation. Traffic runs with and without sender gaps and receiver
// stalls, and includes one long receiver hold that backs up the input.
// ----------------------------------------------------------------------------
module random_permutation_shuffle_top_tb
    import rps_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [OUT_W-1:0] slot;
        logic [OUT_W-1:0] chosen;
        logic             last;
    } t_draw;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata = '0;   // [30:0] random_word, [31] zero pad
    logic [0:0]       s_tuser = '0;   // [0] restart
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;        // [7:0] slot, [15:8] chosen_index
    logic             m_tlast;        // last

    // Shuffle model state
    logic [CFG_W-1:0] len_reg = PERM_LEN_RST;
    int unsigned      slots_left = 0;
    logic [OUT_W-1:0] index_copy [DEF_MAX_LEN];
    bit               touched [DEF_MAX_LEN];
    t_draw            pending_draws [$];

    // Traffic shaping
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_token = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    // Bookkeeping
    int unsigned cycle_count = 0;
    int unsigned errors = 0;
    int unsigned items_sent = 0;
    int unsigned restarts_sent = 0;
    int unsigned results_seen = 0;
    int unsigned perms_done = 0;
    int unsigned input_stalls = 0;
    int unsigned cfg_writes = 0;

    random_permutation_shuffle_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Clamp a length register value to 1..MAX_LEN
    function automatic int unsigned clamp_length(input logic [CFG_W-1:0] value);
        if (value == 0) begin
            return 1;
        end
        if (value > DEF_MAX_LEN) begin
            return DEF_MAX_LEN;
        end
        return 32'(value);
    endfunction

    // Advance the shuffle by one draw and return the element it places
    function automatic t_draw shuffle_draw(input logic [30:0] word, input logic restart);
        t_draw       d;
        int unsigned i;
        int unsigned r;
        int unsigned val_r;
        int unsigned val_i;
        if (restart || slots_left == 0) begin
            foreach (touched[k]) touched[k] = 1'b0;
            slots_left = clamp_length(len_reg);
        end
        i = slots_left - 1;
        r = 32'(word) % slots_left;
        val_r = touched[r] ? 32'(index_copy[r]) : r;
        val_i = touched[i] ? 32'(index_copy[i]) : i;
        index_copy[r] = val_i[OUT_W-1:0];
        touched[r] = 1'b1;
        slots_left = i;
        d.slot = i[OUT_W-1:0];
        d.chosen = val_r[OUT_W-1:0];
        d.last = (i == 0);
        return d;
    endfunction

    // Offer one request after a random gap and predict its result
    task automatic send_item(input logic [30:0] word, input logic restart);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, word};
        s_tuser <= restart;
        do @(posedge i_clk); while (!s_tready);
        pending_draws.push_back(shuffle_draw(word, restart));
        items_sent++;
        if (restart) begin
            restarts_sent++;
        end
    endtask

    // Drop the request stream, wait for the block to drain, then write the length
    task automatic write_perm_length(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        wait (pending_draws.size() == 0);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        len_reg = value;
        cfg_writes++;
    endtask

    function automatic logic [CFG_W-1:0] pick_length();
        case ($urandom_range(0, 39))
            0: return '0;
            1: return 9'd1;
            2: return 9'd2;
            3: return 9'd256;
            4: return 9'd511;
            5: return 9'($urandom_range(257, 510));
            6: return 9'($urandom_range(100, 255));
            default: return 9'($urandom_range(1, 40));
        endcase
    endfunction

    // Reset length of eight with the word extremes and alternating bit patterns
    task automatic test_default_length();
        send_item(31'h0000_0000, 1'b0);
        send_item(31'h7FFF_FFFF, 1'b0);
        send_item(31'h5555_5555, 1'b0);
        send_item(31'h2AAA_AAAA, 1'b0);
        send_item(31'h7FFF_FFFF, 1'b0);
        send_item(31'h0000_0001, 1'b0);
        send_item(31'h0000_0000, 1'b0);
        send_item(31'h4000_0000, 1'b0);
    endtask

    // Single-element permutations, from a length of one and a length of zero
    task automatic test_single_element();
        write_perm_length(9'd1);
        send_item(31'h7FFF_FFFF, 1'b0);
        send_item(31'h0000_0000, 1'b1);
        write_perm_length('0);
        send_item(31'h1234_5678, 1'b0);
        send_item(31'h7FFF_FFFF, 1'b0);
    endtask

    // Change the length mid-permutation, then abandon a run with restart
    task automatic test_length_change_and_restart();
        write_perm_length(9'd6);
        send_item(31'h7FFF_FFFF, 1'b0);
        send_item(31'h0000_0003, 1'b0);
        write_perm_length(9'd3);
        send_item(31'h2AAA_AAAA, 1'b0);
        send_item(31'h5555_5555, 1'b0);
        send_item(31'h0000_0000, 1'b0);
        send_item(31'h7FFF_FFFF, 1'b0);
        send_item(31'h0000_0002, 1'b0);
        send_item(31'h0000_0001, 1'b1);
        send_item(31'h7FFF_FFFE, 1'b1);
    endtask

    // A run at an over-range length, clamped to the maximum; the first requests finish the open permutation
    task automatic test_max_length();
        write_perm_length(9'h1FF);
        repeat (DEF_MAX_LEN) send_item(31'($urandom()), 1'b0);
    endtask

    // Hold the receiver off long enough that the block stalls its input
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        write_perm_length(9'd40);
        hold_token++;
        repeat (60) send_item(31'($urandom()), 1'b0);
    endtask

    // Mostly whole permutations with random words, occasional restarts
    task automatic test_random_traffic(input int unsigned send_pct,
                                       input int unsigned stall_in,
                                       input int unsigned budget);
        int unsigned sent;
        int unsigned eff;
        int unsigned run_items;
        sent = 0;
        send_idle_pct = send_pct;
        stall_pct = stall_in;
        while (sent < budget) begin
            write_perm_length(pick_length());
            eff = clamp_length(len_reg);
            if (eff > 40) begin
                run_items = eff;
            end else begin
                run_items = eff * $urandom_range(1, 4) + $urandom_range(0, eff);
            end
            if (run_items > budget - sent) begin
                run_items = budget - sent;
            end
            repeat (run_items) begin
                send_item(31'($urandom()), ($urandom_range(0, 24) == 0));
            end
            sent += run_items;
        end
    endtask

    // Receiver: random stalls, plus a long hold when one is requested
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Check each result against the oldest predicted draw
    always @(posedge i_clk) begin
        t_draw want;
        t_draw got;
        if (i_rst_n) begin
            if (s_tvalid && !s_tready) begin
                input_stalls++;
            end
            if (m_tvalid && m_tready) begin
                got.slot = m_tdata[7:0];
                got.chosen = m_tdata[15:8];
                got.last = m_tlast;
                results_seen++;
                if (m_tlast) begin
                    perms_done++;
                end
                if (pending_draws.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result slot %0d chosen %0d last %0b",
                             $realtime, got.slot, got.chosen, got.last);
                end else begin
                    want = pending_draws.pop_front();
                    if (got.slot !== want.slot || got.chosen !== want.chosen ||
                        got.last !== want.last) begin
                        errors++;
                        $display({"%0t: mismatch expected slot %0d chosen %0d last %0b,",
                                  " got slot %0d chosen %0d last %0b"},
                                 $realtime, want.slot, want.chosen, want.last,
                                 got.slot, got.chosen, got.last);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("random_permutation_shuffle_top test failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_length();
        test_single_element();
        test_length_change_and_restart();
        test_max_length();
        test_output_backpressure();
        test_random_traffic(0, 0, 200);
        test_random_traffic(80, 0, 200);
        test_random_traffic(0, 80, 200);
        test_random_traffic(34, 34, 200);

        // Drain the output and give the block time to settle
        s_tvalid <= 1'b0;
        wait (pending_draws.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d restarts), %0d results, %0d permutations",
                 items_sent, restarts_sent, results_seen, perms_done);
        $display("Length writes: %0d; requests held off for %0d cycles in total",
                 cfg_writes, input_stalls);
        if (errors == 0) begin
            $display("random_permutation_shuffle_top test passed");
        end else begin
            $display("random_permutation_shuffle_top test failed");
        end
        $finish;
    end

endmodule
